@@ hdl/resource_pressure_monitor_defines.svh @@
// ----------------------------------------------------------------------------
// Resource pressure monitor assertion macros
// Shared wrappers for the concurrent checks in the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef RESOURCE_PRESSURE_MONITOR_DEFINES_SVH
`define RESOURCE_PRESSURE_MONITOR_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define RPM_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RPM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/rpm_pkg.sv @@
// ----------------------------------------------------------------------------
// Resource pressure monitor package
// Field widths, register indexes, event codes and ratio unit constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rpm_pkg;

	localparam int unsigned MemWidth   = 48;
	localparam int unsigned TickWidth  = 64;
	localparam int unsigned PctWidth   = 7;
	localparam int unsigned RatioSteps = 14;
	localparam int unsigned StepWidth  = 4;

	localparam logic [PctWidth-1:0] ScaleFactor = 7'd100;
	localparam logic [PctWidth-1:0] FullPercent = 7'd100;

	typedef logic [PctWidth-1:0]  pct_t;
	typedef logic [MemWidth-1:0]  mem_t;
	typedef logic [TickWidth-1:0] tick_t;

	typedef enum logic [1:0] {
		CfgCriticalEnter = 2'd0,
		CfgCriticalLeave = 2'd1,
		CfgWarningEnter  = 2'd2,
		CfgWarningLeave  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EvNone      = 2'd0,
		EvCritical  = 2'd1,
		EvWarning   = 2'd2,
		EvRecovered = 2'd3
	} event_t;

endpackage

`default_nettype wire

@@ hdl/rpm_if.sv @@
// ----------------------------------------------------------------------------
// Resource pressure monitor channels
// Valid/ready channels for sample beats, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpm_sample_if;
	logic          valid;
	logic          ready;
	logic          mem_ok;
	rpm_pkg::mem_t  avail_bytes;
	rpm_pkg::mem_t  total_bytes;
	logic          times_ok;
	rpm_pkg::tick_t idle_ticks;
	rpm_pkg::tick_t kernel_ticks;
	rpm_pkg::tick_t user_ticks;

	modport source (output valid, mem_ok, avail_bytes, total_bytes, times_ok,
		idle_ticks, kernel_ticks, user_ticks, input ready);
	modport sink (input valid, mem_ok, avail_bytes, total_bytes, times_ok,
		idle_ticks, kernel_ticks, user_ticks, output ready);
endinterface

interface rpm_result_if;
	logic            valid;
	logic            ready;
	rpm_pkg::pct_t   free_percent;
	rpm_pkg::pct_t   busy_percent;
	logic            critical_now;
	logic            warning_now;
	rpm_pkg::event_t event_code;

	modport source (output valid, free_percent, busy_percent, critical_now,
		warning_now, event_code, input ready);
	modport sink (input valid, free_percent, busy_percent, critical_now,
		warning_now, event_code, output ready);
endinterface

interface rpm_cfg_if;
	logic              valid;
	logic              ready;
	rpm_pkg::cfg_idx_t reg_index;
	rpm_pkg::pct_t     wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/resource_pressure_monitor.sv @@
// ----------------------------------------------------------------------------
// Resource pressure monitor
// Free/busy percentages and two-level memory pressure hysteresis per sample.
// ----------------------------------------------------------------------------
// Each sample beat yields exactly one result beat. A sample steps through
// the free setup, delta and hysteresis states when no ratio is needed;
// forming the counter deltas adds the sum and busy setup states, and each
// ratio that runs adds its steps in the shared reduce unit, which performs
// one 64-bit add-and-reduce per cycle and needs 14 steps for each
// floor(n*100/d). The sample channel is ready only while the sequencer is
// idle; a finished result waits in its own output register, so the next
// sample is taken while the previous result is still pending.
// The free ratio runs only when mem_ok is set, total is nonzero and avail is
// below total (avail at or above total gives 100). The busy ratio runs only
// for a valid, non-first sample with a nonzero counter sum that is not
// exceeded by the idle delta. Register writes are always ready and take
// effect on the next cycle; write them only while the monitor is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "resource_pressure_monitor_defines.svh"

module resource_pressure_monitor (
	input  wire            clk,
	input  wire            arst_n,
	rpm_cfg_if.sink        cfg,
	rpm_sample_if.sink     sample,
	rpm_result_if.source   result
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FSET,
		ST_FRUN,
		ST_DELTA,
		ST_SUM,
		ST_BSET,
		ST_BRUN,
		ST_HYST
	} state_t;

	state_t state_q;

	// Threshold registers
	rpm_pkg::pct_t crit_enter_q, crit_leave_q, warn_enter_q, warn_leave_q;

	// Captured sample
	logic           mem_ok_q, times_ok_q;
	rpm_pkg::mem_t  avail_q, total_q;
	rpm_pkg::tick_t idle_q, kern_q, user_q;

	// Persistent monitor state
	rpm_pkg::tick_t last_idle_q, last_kern_q, last_user_q;
	rpm_pkg::pct_t  held_free_q, held_busy_q;
	logic           crit_q, warn_q;

	// Counter deltas
	rpm_pkg::tick_t di_q, dk_q, du_q, sum_q;

	// Shared reduce unit operands
	rpm_pkg::tick_t n_q, d_q, r_q;
	rpm_pkg::pct_t  q_q;
	logic [rpm_pkg::StepWidth-1:0] step_q;

	// Output register
	logic            out_valid_q;
	rpm_pkg::pct_t   out_free_q, out_busy_q;
	logic            out_crit_q, out_warn_q;
	rpm_pkg::event_t out_event_q;

	// ------------------------------------------------------------------
	// Shared reduce unit: r' = (r + a) mod d, quotient bit on wrap.
	// Even steps double r (and shift q), odd steps add n when the
	// matching bit of the scale factor is set.
	// ------------------------------------------------------------------
	logic                       is_double;
	logic [2:0]                 bit_idx;
	rpm_pkg::tick_t             addend;
	logic [rpm_pkg::TickWidth:0] acc_sum;
	logic                       wrap;
	rpm_pkg::tick_t             r_next;
	rpm_pkg::pct_t              q_base, q_next;
	logic                       last_step;

	always_comb begin
		is_double = ~step_q[0];
		bit_idx   = 3'd6 - step_q[3:1];
		if (is_double) begin
			addend = r_q;
		end else if (rpm_pkg::ScaleFactor[bit_idx]) begin
			addend = n_q;
		end else begin
			addend = '0;
		end
		acc_sum = {1'b0, r_q} + {1'b0, addend};
		wrap    = (acc_sum >= {1'b0, d_q});
		r_next  = wrap ? rpm_pkg::TickWidth'(acc_sum - {1'b0, d_q})
			: acc_sum[rpm_pkg::TickWidth-1:0];
		q_base  = is_double ? {q_q[rpm_pkg::PctWidth-2:0], 1'b0} : q_q;
		q_next  = q_base + rpm_pkg::PctWidth'(wrap);
		last_step = (step_q == rpm_pkg::StepWidth'(rpm_pkg::RatioSteps - 1));
	end

	// Busy numerator and the idle-above-sum check share one subtractor
	logic [rpm_pkg::TickWidth:0] busy_diff;
	assign busy_diff = {1'b0, sum_q} - {1'b0, di_q};

	// ------------------------------------------------------------------
	// Hysteresis on the held free percent, checked in priority order
	// ------------------------------------------------------------------
	logic            crit_next, warn_next;
	rpm_pkg::event_t ev_next;

	always_comb begin
		crit_next = crit_q;
		warn_next = warn_q;
		ev_next   = rpm_pkg::EvNone;
		priority if (held_free_q < crit_enter_q) begin
			if (!crit_q) begin
				crit_next = 1'b1;
				warn_next = 1'b1;
				ev_next   = rpm_pkg::EvCritical;
			end
		end else if (held_free_q < warn_enter_q) begin
			crit_next = crit_q && !(held_free_q > crit_leave_q);
			warn_next = 1'b1;
			if (!warn_q && !crit_next) begin
				ev_next = rpm_pkg::EvWarning;
			end
		end else if (held_free_q > warn_leave_q) begin
			crit_next = 1'b0;
			warn_next = 1'b0;
			if (crit_q || warn_q) begin
				ev_next = rpm_pkg::EvRecovered;
			end
		end else begin
			crit_next = crit_q;
		end
	end

	logic out_free_slot;
	assign out_free_slot = !out_valid_q || result.ready;

	// ------------------------------------------------------------------
	// Handshakes
	// ------------------------------------------------------------------
	assign sample.ready        = (state_q == ST_IDLE);
	assign cfg.ready           = 1'b1;
	assign result.valid        = out_valid_q;
	assign result.free_percent = out_free_q;
	assign result.busy_percent = out_busy_q;
	assign result.critical_now = out_crit_q;
	assign result.warning_now  = out_warn_q;
	assign result.event_code   = out_event_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_enter_q <= 7'd25;
			crit_leave_q <= 7'd35;
			warn_enter_q <= 7'd50;
			warn_leave_q <= 7'd60;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				rpm_pkg::CfgCriticalEnter: crit_enter_q <= cfg.wdata;
				rpm_pkg::CfgCriticalLeave: crit_leave_q <= cfg.wdata;
				rpm_pkg::CfgWarningEnter:  warn_enter_q <= cfg.wdata;
				rpm_pkg::CfgWarningLeave:  warn_leave_q <= cfg.wdata;
			endcase
		end
	end

	// Sample capture and datapath registers without reset
	always_ff @(posedge clk) begin
		if (sample.valid && state_q == ST_IDLE) begin
			mem_ok_q   <= sample.mem_ok;
			avail_q    <= sample.avail_bytes;
			total_q    <= sample.total_bytes;
			times_ok_q <= sample.times_ok;
			idle_q     <= sample.idle_ticks;
			kern_q     <= sample.kernel_ticks;
			user_q     <= sample.user_ticks;
		end
		unique case (state_q)
			ST_FSET: begin
				// load the free ratio operands; they are used only when avail is below total
				n_q    <= rpm_pkg::TickWidth'(avail_q);
				d_q    <= rpm_pkg::TickWidth'(total_q);
				r_q    <= '0;
				q_q    <= '0;
				step_q <= '0;
			end
			ST_DELTA: begin
				di_q <= idle_q - last_idle_q;
				dk_q <= kern_q - last_kern_q;
				du_q <= user_q - last_user_q;
			end
			ST_SUM: begin
				sum_q <= dk_q + du_q;
			end
			ST_BSET: begin
				n_q    <= busy_diff[rpm_pkg::TickWidth-1:0];
				d_q    <= sum_q;
				r_q    <= '0;
				q_q    <= '0;
				step_q <= '0;
			end
			ST_FRUN, ST_BRUN: begin
				r_q    <= r_next;
				q_q    <= q_next;
				step_q <= step_q + rpm_pkg::StepWidth'(1);
			end
			ST_HYST: begin
				if (out_free_slot) begin
					out_free_q  <= held_free_q;
					out_busy_q  <= held_busy_q;
					out_crit_q  <= crit_next;
					out_warn_q  <= warn_next;
					out_event_q <= ev_next;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result valid: raise when a beat is loaded, drop once it is taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HYST && out_free_slot) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and held state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_idle_q <= '0;
			last_kern_q <= '0;
			last_user_q <= '0;
			held_free_q <= rpm_pkg::FullPercent;
			held_busy_q <= '0;
			crit_q      <= 1'b0;
			warn_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						state_q <= ST_FSET;
					end
				end
				ST_FSET: begin
					// hold the previous free percent on a failed or empty reading
					if (mem_ok_q && total_q != '0) begin
						if (avail_q >= total_q) begin
							held_free_q <= rpm_pkg::FullPercent;
							state_q     <= ST_DELTA;
						end else begin
							state_q <= ST_FRUN;
						end
					end else begin
						state_q <= ST_DELTA;
					end
				end
				ST_FRUN: begin
					if (last_step) begin
						held_free_q <= q_next;
						state_q     <= ST_DELTA;
					end
				end
				ST_DELTA: begin
					if (!times_ok_q) begin
						// repeat held busy, leave counters alone
						state_q <= ST_HYST;
					end else if (last_kern_q == '0) begin
						// first sample: latch counters, report zero
						last_idle_q <= idle_q;
						last_kern_q <= kern_q;
						last_user_q <= user_q;
						held_busy_q <= '0;
						state_q     <= ST_HYST;
					end else begin
						last_idle_q <= idle_q;
						last_kern_q <= kern_q;
						last_user_q <= user_q;
						state_q     <= ST_SUM;
					end
				end
				ST_SUM: begin
					state_q <= ST_BSET;
				end
				ST_BSET: begin
					priority if (sum_q == '0) begin
						state_q <= ST_HYST;
					end else if (busy_diff[rpm_pkg::TickWidth]) begin
						// idle delta above the sum: clamp to zero
						held_busy_q <= '0;
						state_q     <= ST_HYST;
					end else begin
						state_q <= ST_BRUN;
					end
				end
				ST_BRUN: begin
					if (last_step) begin
						held_busy_q <= q_next;
						state_q     <= ST_HYST;
					end
				end
				ST_HYST: begin
					// advance only when the output register can take the beat
					if (out_free_slot) begin
						crit_q  <= crit_next;
						warn_q  <= warn_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`RPM_ASSERT_HOLDS(a_crit_needs_warn, clk, arst_n, !crit_q || warn_q, "critical set without warning")
	`RPM_ASSERT_IMPLIES(a_rem_below_div, clk, arst_n, (state_q == ST_FRUN || state_q == ST_BRUN), r_q < d_q, "ratio remainder not below divisor")
	`RPM_ASSERT_IMPLIES(a_ratio_in_range, clk, arst_n, (state_q == ST_FRUN || state_q == ST_BRUN) && last_step, q_next <= rpm_pkg::ScaleFactor, "ratio above one hundred")
	`RPM_ASSERT_IMPLIES(a_crit_event_flag, clk, arst_n, out_valid_q && out_event_q == rpm_pkg::EvCritical, out_crit_q && out_warn_q, "critical event without both flags")

endmodule

`default_nettype wire
